### hw/rtl/pcg_pkg.sv
package pcg_pkg;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;

    localparam int XSH_SHIFT_A = 18;
    localparam int XSH_SHIFT_B = 27;
    localparam int ROT_LSB     = 59;

    localparam int REM_STEPS = 32;
    localparam int REM_CNT_W = $clog2(REM_STEPS);

    // command codes
    localparam logic [1:0] CMD_RESEED  = 2'd0;
    localparam logic [1:0] CMD_RAW     = 2'd1;
    localparam logic [1:0] CMD_BOUNDED = 2'd2;

    typedef struct packed {
        logic        done;
        logic [63:0] state;
    } t_step_rsp;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_rem_rsp;

    // XSH-RR output of one LCG state
    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [63:0] mix_w;
        logic [31:0] mixed;
        logic [4:0]  rot;
        logic [63:0] dbl;
        mix_w = ((old >> XSH_SHIFT_A) ^ old) >> XSH_SHIFT_B;
        mixed = mix_w[31:0];
        rot   = old[ROT_LSB +: 5];
        dbl   = {mixed, mixed} >> rot;
        return dbl[31:0];
    endfunction

endpackage

### hw/rtl/pcg_if.sv
interface pcg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] seed;
    logic [31:0] bound;

    modport source (output valid, output cmd, output seed, output bound, input ready);
    modport sink   (input valid, input cmd, input seed, input bound, output ready);
endinterface

interface pcg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### hw/rtl/pcg_step.sv
module pcg_step
    import pcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_state,
    input  logic [63:0] i_inc,
    output t_step_rsp   o_rsp
);

    // state*MULT + inc mod 2^64 on one 32x32 multiplier:
    // lo*lo, hi*lo, lo*hi, accumulated one partial product per cycle
    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [1:0]  r_ph;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_op_a;
    logic [31:0] w_op_m;
    logic [63:0] w_addend;

    always_comb begin
        w_op_a   = r_a[31:0];
        w_op_m   = PCG_MULT[31:0];
        w_addend = '0;
        case (r_ph)
            2'd0: begin
                w_op_a = r_a[31:0];
                w_op_m = PCG_MULT[31:0];
            end
            2'd1: begin
                w_op_a   = r_a[63:32];
                w_op_m   = PCG_MULT[31:0];
                w_addend = r_prod;
            end
            2'd2: begin
                w_op_a   = r_a[31:0];
                w_op_m   = PCG_MULT[63:32];
                w_addend = {r_prod[31:0], 32'd0};
            end
            default: begin
                w_addend = {r_prod[31:0], 32'd0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 2'd0;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_state;
            r_acc <= i_inc;
        end else if (r_busy) begin
            r_prod <= w_op_a * w_op_m;
            r_acc  <= r_acc + w_addend;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.state = r_acc;

endmodule

### hw/rtl/pcg_rem.sv
module pcg_rem
    import pcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_div,
    output t_rem_rsp    o_rsp
);

    // restoring division, one quotient bit per cycle, remainder kept
    logic [31:0]          r_num;
    logic [31:0]          r_div;
    logic [31:0]          r_rem;
    logic [REM_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {r_rem, r_num[31]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == REM_CNT_W'(REM_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_div <= i_div;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= w_diff[32] ? w_trial[31:0] : w_diff[31:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

### hw/rtl/pcg32_random_generator.sv
// channel   dir  handshake      payload
// i_req     in   valid/ready    cmd[1:0], seed[63:0], bound[31:0]
// o_rsp     out  valid/ready    value[31:0]
//
// Reseed: two LCG steps on the 32x32 multiplier, the seed added after the first.
// Raw draw: one LCG step. Bounded draw: threshold, redraws while below it, and
// the remainder unit runs once for the threshold and once for the result.
// Bound zero answers 0 without a draw; cmd 3 is dropped with no answer.
// Synchronous active-low reset: state 0, increment 1, no result pending.
// A new item is taken while the last result waits in the output register; a
// finished result waits in its own state until that register frees up.
module pcg32_random_generator
    import pcg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcg_req_if.sink       i_req,
    pcg_rsp_if.source     o_rsp
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SD1   = 12'b0000_0000_0010,
        S_SD1W  = 12'b0000_0000_0100,
        S_SD2   = 12'b0000_0000_1000,
        S_SD2W  = 12'b0000_0001_0000,
        S_THR   = 12'b0000_0010_0000,
        S_THRW  = 12'b0000_0100_0000,
        S_DRAW  = 12'b0000_1000_0000,
        S_DRAWW = 12'b0001_0000_0000,
        S_MOD   = 12'b0010_0000_0000,
        S_MODW  = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } t_state;

    t_state      r_st;
    t_state      n_st;
    logic [63:0] r_state;
    logic [63:0] r_inc;
    logic [63:0] r_seed;
    logic [31:0] r_bound;
    logic [31:0] r_thr;
    logic [31:0] r_val;
    logic [31:0] r_res;
    logic        r_bounded;
    logic        r_ovalid;
    logic [31:0] r_oval;

    logic        w_accept;
    logic        w_out_free;
    logic        w_step_start;
    logic        w_rem_start;
    logic [31:0] w_rem_num;
    t_step_rsp   w_step;
    t_rem_rsp    w_rem;

    assign i_req.ready = (r_st == S_IDLE);
    assign w_accept    = i_req.valid && (r_st == S_IDLE);
    assign w_out_free  = !r_ovalid || o_rsp.ready;

    assign w_step_start = (r_st == S_SD1) || (r_st == S_SD2) || (r_st == S_DRAW);
    assign w_rem_start  = (r_st == S_THR) || (r_st == S_MOD);
    assign w_rem_num    = (r_st == S_THR) ? (32'd0 - r_bound) : r_val;

    pcg_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_step_start),
        .i_state (r_state),
        .i_inc   (r_inc),
        .o_rsp   (w_step)
    );

    pcg_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_num   (w_rem_num),
        .i_div   (r_bound),
        .o_rsp   (w_rem)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.cmd)
                        CMD_RESEED:  n_st = S_SD1;
                        CMD_RAW:     n_st = S_DRAW;
                        CMD_BOUNDED: n_st = (i_req.bound == 32'd0) ? S_EMIT : S_THR;
                        default:     n_st = S_IDLE;
                    endcase
                end
            end
            S_SD1:   n_st = S_SD1W;
            S_SD1W:  if (w_step.done) n_st = S_SD2;
            S_SD2:   n_st = S_SD2W;
            S_SD2W:  if (w_step.done) n_st = S_IDLE;
            S_THR:   n_st = S_THRW;
            S_THRW:  if (w_rem.done) n_st = S_DRAW;
            S_DRAW:  n_st = S_DRAWW;
            S_DRAWW: begin
                if (w_step.done) begin
                    if (!r_bounded) begin
                        n_st = S_EMIT;
                    end else if (r_val >= r_thr) begin
                        n_st = S_MOD;
                    end else begin
                        n_st = S_DRAW;
                    end
                end
            end
            S_MOD:   n_st = S_MODW;
            S_MODW:  if (w_rem.done) n_st = S_EMIT;
            S_EMIT:  if (w_out_free) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_state  <= 64'd0;
            r_inc    <= 64'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= (r_st == S_EMIT && w_out_free) ? 1'b1 : (r_ovalid && !o_rsp.ready);
            if (w_accept && i_req.cmd == CMD_RESEED) begin
                r_state <= 64'd0;
                r_inc   <= {i_req.seed[62:0], 1'b1};
            end
            if (w_step.done) begin
                // first reseed step folds in the seed
                r_state <= (r_st == S_SD1W) ? (w_step.state + r_seed) : w_step.state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seed    <= i_req.seed;
            r_bound   <= i_req.bound;
            r_bounded <= (i_req.cmd == CMD_BOUNDED);
            r_res     <= 32'd0;
        end
        if (r_st == S_DRAW) begin
            r_val <= xsh_rr(r_state);
        end
        if (r_st == S_THRW && w_rem.done) begin
            r_thr <= w_rem.rem;
        end
        if (r_st == S_DRAWW && w_step.done && !r_bounded) begin
            r_res <= r_val;
        end
        if (r_st == S_MODW && w_rem.done) begin
            r_res <= w_rem.rem;
        end
        if (r_st == S_EMIT && w_out_free) begin
            r_oval <= r_res;
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.value = r_oval;

`ifndef SYNTHESIS
    a_inc_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inc[0])
        else $error("increment lost its low bit");

    a_step_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step.done |-> (r_st == S_SD1W || r_st == S_SD2W || r_st == S_DRAWW))
        else $error("step unit finished outside a wait state");

    a_rem_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem.done |-> (r_st == S_THRW || r_st == S_MODW))
        else $error("remainder unit finished outside a wait state");

    a_accepted_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_MODW) |-> (r_val >= r_thr))
        else $error("reduced a draw below the threshold");

    a_bound_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_THRW || r_st == S_MODW) |-> (r_bound != 32'd0))
        else $error("remainder by zero bound");
`endif

endmodule

### tb/sv/pcg32_random_generator_tb.sv
`timescale 1ns / 100ps

module pcg32_random_generator_tb;
    import pcg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned N_RANDOM    = 1850;
    localparam int unsigned DRAIN_AT    = 1000;
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 200;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] seed;
        logic [31:0] bound;
        bit          drain;  // wait for all results before offering this item
    } req_item_t;

    logic i_clk;
    logic i_rst_n;

    pcg_req_if req_if();
    pcg_rsp_if rsp_if();

    pcg32_random_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    req_item_t   pending_reqs[$];
    logic [31:0] want_values[$];

    // generator copy kept in step with the block
    logic [63:0] gen_state;
    logic [63:0] gen_inc;

    logic        req_fired;
    int unsigned accepted_reqs;
    int unsigned fail_count;
    int unsigned rx_hold_left;
    bit          rx_hold_done;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // sender and receiver swap idle rates, then both run flat out
    always_comb begin
        if (accepted_reqs < 620) begin
            tx_idle_pct = 6;
            rx_idle_pct = 62;
        end else if (accepted_reqs < 1240) begin
            tx_idle_pct = 62;
            rx_idle_pct = 6;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    function automatic logic [31:0] pcg_draw();
        logic [63:0] prev;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [4:0]  lrot;
        prev      = gen_state;
        gen_state = prev * PCG_MULT + gen_inc;
        xs        = 32'(((prev >> XSH_SHIFT_A) ^ prev) >> XSH_SHIFT_B);
        rot       = prev[63:59];
        lrot      = 5'd0 - rot;
        return (xs >> rot) | (xs << lrot);
    endfunction

    function automatic void predict_req(input logic [1:0] cmd, input logic [63:0] seed,
                                        input logic [31:0] bound);
        logic [31:0] thr;
        logic [31:0] r;
        case (cmd)
            CMD_RESEED: begin
                gen_state = 64'd0;
                gen_inc   = {seed[62:0], 1'b1};
                void'(pcg_draw());
                gen_state = gen_state + seed;
                void'(pcg_draw());
            end
            CMD_RAW: begin
                want_values.push_back(pcg_draw());
            end
            CMD_BOUNDED: begin
                if (bound == 32'd0) begin
                    want_values.push_back(32'd0);
                end else begin
                    thr = (32'd0 - bound) % bound;
                    do r = pcg_draw(); while (r < thr);
                    want_values.push_back(r % bound);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_bound();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)  return 32'd0;
        if (sel < 45) return $urandom_range(1, 16);
        if (sel < 60) return $urandom_range(17, 100000);
        // just above half: threshold near 2^31, many rejections
        if (sel < 70) return 32'h8000_0000 + $urandom_range(0, 255);
        if (sel < 78) return 32'hFFFF_FFFF - $urandom_range(0, 255);
        return $urandom();
    endfunction

    task automatic push_req(input logic [1:0] cmd, input logic [63:0] seed,
                            input logic [31:0] bound, input bit drain);
        req_item_t it;
        it.cmd   = cmd;
        it.seed  = seed;
        it.bound = bound;
        it.drain = drain;
        pending_reqs.push_back(it);
    endtask

    // result check and request prediction share one process so the queue
    // sees a fixed order within an edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gen_state = 64'd0;
            gen_inc   = 64'd1;
            req_fired     <= 1'b0;
            accepted_reqs <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (want_values.size() == 0) begin
                    $error("value: no item expected, actual %h", rsp_if.value);
                    fail_count++;
                end else if (rsp_if.value !== want_values[0]) begin
                    $error("value mismatch: expected %h, actual %h", want_values[0],
                           rsp_if.value);
                    fail_count++;
                    void'(want_values.pop_front());
                end else begin
                    void'(want_values.pop_front());
                end
            end
            if (req_if.valid && req_if.ready) begin
                predict_req(req_if.cmd, req_if.seed, req_if.bound);
                accepted_reqs <= accepted_reqs + 1;
            end
            req_fired <= req_if.valid && req_if.ready;
        end
    end

    // one long receiver stall while the sender keeps offering items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end else if (!rx_hold_done && accepted_reqs >= HOLD_AT) begin
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fired) begin
            if (pending_reqs.size() != 0
                && !(pending_reqs[0].drain && want_values.size() != 0)
                && $urandom_range(0, 99) >= tx_idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.cmd   <= pending_reqs[0].cmd;
                req_if.seed  <= pending_reqs[0].seed;
                req_if.bound <= pending_reqs[0].bound;
                void'(pending_reqs.pop_front());
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        int unsigned n_real;
        int unsigned sel;
        logic [1:0]  c;
        fail_count   = 0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd   = CMD_RAW;
        req_if.seed  = 64'd0;
        req_if.bound = 32'd0;
        rsp_if.ready = 1'b0;

        // directed: draws straight from the reset state, extreme seeds and bounds
        push_req(CMD_RAW,     64'd0, 32'd0, 1'b0);
        push_req(CMD_RAW,     64'd0, 32'd0, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'd0, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'd1, 1'b0);
        push_req(CMD_RESEED,  64'd0, 32'd0, 1'b0);
        push_req(CMD_RAW,     64'd0, 32'd0, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'hFFFF_FFFF, 1'b0);
        push_req(CMD_RESEED,  64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
        push_req(CMD_RAW,     64'd0, 32'd0, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'h8000_0000, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'h8000_0001, 1'b0);
        push_req(CMD_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_req(CMD_RAW,     64'd0, 32'd0, 1'b0);
        push_req(CMD_RESEED,  64'h8000_0000_0000_0000, 32'd0, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'd2, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'd3, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'h7FFF_FFFF, 1'b0);
        push_req(CMD_RESEED,  64'd42, 32'd0, 1'b0);
        push_req(CMD_RAW,     64'd0, 32'd0, 1'b0);
        push_req(CMD_BOUNDED, 64'd0, 32'd6, 1'b0);
        push_req(CMD_BOUNDED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
        push_req(CMD_RAW,     64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

        n_real = 0;
        while (n_real < N_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (sel < 10)      c = CMD_RESEED;
            else if (sel < 50) c = CMD_RAW;
            else if (sel < 95) c = CMD_BOUNDED;
            else               c = CMD_UNUSED;
            push_req(c, {$urandom(), $urandom()}, pick_bound(), n_real == DRAIN_AT);
            if (c != CMD_UNUSED) n_real++;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_if.valid) @(posedge i_clk);
        while (want_values.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[pcg32_random_generator] OK");
        end else begin
            $display("[pcg32_random_generator] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[pcg32_random_generator] ERROR");
        $finish;
    end

endmodule
